>>> rtl/lsq_pkg.sv
// Shared widths, codes, command/status structs and the multiply step table of the line fitter.
package lsq_pkg;

    localparam int X_W        = 16;
    localparam int Y_W        = 16;
    localparam int OUT_W      = 48;
    localparam int FRAC_BITS  = 16;
    localparam int MAX_POINTS = 1024;

    localparam int LOG_PTS = $clog2(MAX_POINTS);
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int SUM_W   = X_W + LOG_PTS;            // sum of x, sum of y
    localparam int SXY_W   = X_W + Y_W + LOG_PTS;      // sum of x*y
    localparam int SXX_W   = 2 * X_W - 1 + LOG_PTS;    // sum of x*x (never negative)

    // Shared multiplier: A operand times one chunk of the B operand per step.
    localparam int MA_W    = SUM_W + 1;
    localparam int MB_W    = SXY_W;
    localparam int LO_W    = MB_W / 2;
    localparam int HI_W    = MB_W - LO_W;
    localparam int CH_W    = HI_W + 1;
    localparam int PROD_W  = MA_W + CH_W;
    localparam int ACC_W   = 70;
    localparam int MUL_LAT = 2;

    localparam int N_STEPS = 12;
    localparam int STEP_W  = $clog2(N_STEPS);

    // Divider: magnitude of numerator with fraction bits appended, over |D|.
    localparam int DEN_W   = 52;
    localparam int NUM_W   = ACC_W + FRAC_BITS;
    localparam int QCNT_W  = $clog2(NUM_W);

    typedef enum logic [1:0] {
        FIT_OK       = 2'd0,
        FIT_DEN_ZERO = 2'd1,
        FIT_TOO_MANY = 2'd2
    } t_fit_status;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_DRAIN,
        ST_MUL,
        ST_MWAIT,
        ST_CHECK,
        ST_DIV_B,
        ST_DIV_A,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        ASEL_N,
        ASEL_SX,
        ASEL_SY
    } t_asel;

    typedef enum logic [1:0] {
        BSEL_SXX,
        BSEL_SX,
        BSEL_SY,
        BSEL_SXY
    } t_bsel;

    typedef enum logic [1:0] {
        DEST_DEN,
        DEST_BNUM,
        DEST_ANUM
    } t_dest;

    typedef struct packed {
        t_asel asel;
        t_bsel bsel;
        t_dest dest;
        logic  hi;
        logic  sub;
    } t_mul_op;

    typedef struct packed {
        logic    pt_load;
        logic    sum_clr;
        logic    fit_clr;
        logic    mul_valid;
        t_mul_op mul_op;
        logic    div_start;
        logic    div_num_a;
        logic    cap_b;
        logic    cap_a;
        logic    out_load;
        logic    out_zero;
    } t_dp_cmd;

    typedef struct packed {
        logic ovf;
        logic den_zero;
        logic div_done;
    } t_dp_stat;

    // Each product takes two steps (low chunk, then high chunk of B).
    //   D    = n*Sxx  - Sx*Sx
    //   bnum = n*Sxy  - Sx*Sy
    //   anum = Sy*Sxx - Sx*Sxy
    function automatic t_mul_op lsq_mul_step(input logic [STEP_W-1:0] idx);
        t_mul_op op;
        op.hi  = idx[0];
        op.sub = idx[1];
        unique case (idx[STEP_W-1:1])
            3'd0: begin
                op.asel = ASEL_N;  op.bsel = BSEL_SXX; op.dest = DEST_DEN;
            end
            3'd1: begin
                op.asel = ASEL_SX; op.bsel = BSEL_SX;  op.dest = DEST_DEN;
            end
            3'd2: begin
                op.asel = ASEL_N;  op.bsel = BSEL_SXY; op.dest = DEST_BNUM;
            end
            3'd3: begin
                op.asel = ASEL_SX; op.bsel = BSEL_SY;  op.dest = DEST_BNUM;
            end
            3'd4: begin
                op.asel = ASEL_SY; op.bsel = BSEL_SXX; op.dest = DEST_ANUM;
            end
            3'd5: begin
                op.asel = ASEL_SX; op.bsel = BSEL_SXY; op.dest = DEST_ANUM;
            end
            default: begin
                op.asel = ASEL_N;  op.bsel = BSEL_SXX; op.dest = DEST_DEN;
            end
        endcase
        return op;
    endfunction

endpackage

>>> rtl/lsq_pt_if.sv
// Point channel: one data point per request, last_point closes the set.
interface lsq_pt_if;
    logic                             valid;
    logic                             ready;
    logic signed [lsq_pkg::X_W-1:0]   x_value;
    logic signed [lsq_pkg::Y_W-1:0]   y_value;
    logic                             last_point;

    modport source (output valid, x_value, y_value, last_point, input ready);
    modport sink   (input valid, x_value, y_value, last_point, output ready);
endinterface

>>> rtl/lsq_fit_if.sv
// Result channel: intercept, slope and status of one fitted set.
interface lsq_fit_if;
    logic                             valid;
    logic                             ready;
    logic signed [lsq_pkg::OUT_W-1:0] intercept_q16;
    logic signed [lsq_pkg::OUT_W-1:0] slope_q16;
    logic [1:0]                       fit_status;

    modport source (output valid, intercept_q16, slope_q16, fit_status, input ready);
    modport sink   (input valid, intercept_q16, slope_q16, fit_status, output ready);
endinterface

>>> rtl/lsq_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module lsq_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lsq_pkg::NUM_W-1:0]   i_num,
    input  logic [lsq_pkg::DEN_W-1:0]   i_den,
    output logic                        o_done,
    output logic [lsq_pkg::NUM_W-1:0]   o_quo
);
    import lsq_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [QCNT_W-1:0] r_cnt;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  n_rem;
    logic [NUM_W-1:0]  r_quo;
    logic [NUM_W-1:0]  n_quo;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W:0]    w_trial;
    logic [DEN_W:0]    w_diff;

    always_comb begin
        w_trial = {r_rem, r_quo[NUM_W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        if (w_trial >= {1'b0, r_den}) begin
            n_rem = w_diff[DEN_W-1:0];
            n_quo = {r_quo[NUM_W-2:0], 1'b1};
        end else begin
            n_rem = w_trial[DEN_W-1:0];
            n_quo = {r_quo[NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == QCNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

>>> rtl/lsq_dp.sv
// Datapath: point sums, shared multiply-accumulate, divider and result registers.
module lsq_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lsq_pkg::t_dp_cmd                  i_cmd,
    input  logic signed [lsq_pkg::X_W-1:0]    i_x,
    input  logic signed [lsq_pkg::Y_W-1:0]    i_y,
    output lsq_pkg::t_dp_stat                 o_stat,
    output logic signed [lsq_pkg::OUT_W-1:0]  o_intercept,
    output logic signed [lsq_pkg::OUT_W-1:0]  o_slope
);
    import lsq_pkg::*;

    // point pipeline
    logic signed [X_W-1:0]       r_px;
    logic signed [Y_W-1:0]       r_py;
    logic signed [X_W+Y_W-1:0]   r_pxy;
    logic signed [2*X_W-1:0]     r_pxx;
    logic                        r_pv;
    logic signed [X_W+Y_W-1:0]   w_xy;
    logic signed [2*X_W-1:0]     w_xx;

    // running sums
    logic [CNT_W-1:0]            r_cnt;
    logic signed [SUM_W-1:0]     r_sx;
    logic signed [SUM_W-1:0]     r_sy;
    logic signed [SXY_W-1:0]     r_sxy;
    logic [SXX_W-1:0]            r_sxx;
    logic                        r_ovf;

    // multiply-accumulate
    logic signed [MA_W-1:0]      w_a;
    logic signed [MB_W-1:0]      w_b;
    logic signed [CH_W-1:0]      w_chunk;
    logic signed [PROD_W-1:0]    w_prod;
    logic signed [PROD_W-1:0]    r_prod;
    t_mul_op                     r_pop;
    logic                        r_mv;
    logic signed [ACC_W-1:0]     w_ext;
    logic signed [ACC_W-1:0]     w_addend;
    logic signed [ACC_W-1:0]     w_tgt;
    logic signed [ACC_W-1:0]     w_sum;
    logic signed [ACC_W-1:0]     r_den;
    logic signed [ACC_W-1:0]     r_bnum;
    logic signed [ACC_W-1:0]     r_anum;

    // division
    logic signed [ACC_W-1:0]     w_num_acc;
    logic [ACC_W-1:0]            w_num_mag;
    logic [NUM_W-1:0]            w_div_num;
    logic [DEN_W-1:0]            w_den_lo;
    logic [DEN_W-1:0]            w_den_mag;
    logic                        w_div_done;
    logic [NUM_W-1:0]            w_quo;
    logic                        r_qneg;
    logic signed [OUT_W-1:0]     r_a;
    logic signed [OUT_W-1:0]     r_b;
    logic signed [OUT_W-1:0]     r_out_a;
    logic signed [OUT_W-1:0]     r_out_b;

    function automatic logic signed [OUT_W-1:0] sat_q(input logic [NUM_W-1:0] q,
                                                       input logic neg);
        logic big;
        if (neg) begin
            big = (|q[NUM_W-1:OUT_W]) || (q[OUT_W-1] && (|q[OUT_W-2:0]));
            return big ? {1'b1, {(OUT_W-1){1'b0}}} : -q[OUT_W-1:0];
        end else begin
            big = |q[NUM_W-1:OUT_W-1];
            return big ? {1'b0, {(OUT_W-1){1'b1}}} : q[OUT_W-1:0];
        end
    endfunction

    // stage 1: products of the incoming point
    assign w_xy = i_x * i_y;
    assign w_xx = i_x * i_x;

    always_ff @(posedge i_clk) begin
        if (i_cmd.pt_load) begin
            r_px  <= i_x;
            r_py  <= i_y;
            r_pxy <= w_xy;
            r_pxx <= w_xx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_cmd.pt_load;
        end
    end

    // stage 2: add into the sums, drop points past the limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.sum_clr) begin
            r_cnt <= '0;
            r_sx  <= '0;
            r_sy  <= '0;
            r_sxy <= '0;
            r_sxx <= '0;
            r_ovf <= 1'b0;
        end else if (r_pv) begin
            if (r_cnt == CNT_W'(MAX_POINTS)) begin
                r_ovf <= 1'b1;
            end else begin
                r_cnt <= r_cnt + 1'b1;
                r_sx  <= r_sx + {{(SUM_W-X_W){r_px[X_W-1]}}, r_px};
                r_sy  <= r_sy + {{(SUM_W-Y_W){r_py[Y_W-1]}}, r_py};
                r_sxy <= r_sxy + {{(SXY_W-X_W-Y_W){r_pxy[X_W+Y_W-1]}}, r_pxy};
                r_sxx <= r_sxx + {{(SXX_W-2*X_W){1'b0}}, r_pxx};
            end
        end
    end

    // shared multiplier: A times one chunk of B
    always_comb begin
        unique case (i_cmd.mul_op.asel)
            ASEL_N:  w_a = {{(MA_W-CNT_W){1'b0}}, r_cnt};
            ASEL_SX: w_a = {{(MA_W-SUM_W){r_sx[SUM_W-1]}}, r_sx};
            ASEL_SY: w_a = {{(MA_W-SUM_W){r_sy[SUM_W-1]}}, r_sy};
            default: w_a = '0;
        endcase
        unique case (i_cmd.mul_op.bsel)
            BSEL_SXX: w_b = {{(MB_W-SXX_W){1'b0}}, r_sxx};
            BSEL_SX:  w_b = {{(MB_W-SUM_W){r_sx[SUM_W-1]}}, r_sx};
            BSEL_SY:  w_b = {{(MB_W-SUM_W){r_sy[SUM_W-1]}}, r_sy};
            BSEL_SXY: w_b = r_sxy;
            default:  w_b = '0;
        endcase
        if (i_cmd.mul_op.hi) begin
            w_chunk = {w_b[MB_W-1], w_b[MB_W-1:LO_W]};
        end else begin
            w_chunk = {{(CH_W-LO_W){1'b0}}, w_b[LO_W-1:0]};
        end
    end

    assign w_prod = w_a * w_chunk;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_valid) begin
            r_prod <= w_prod;
            r_pop  <= i_cmd.mul_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else begin
            r_mv <= i_cmd.mul_valid;
        end
    end

    // accumulate the registered product into its target
    always_comb begin
        w_ext    = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        w_addend = r_pop.hi ? (w_ext <<< LO_W) : w_ext;
        unique case (r_pop.dest)
            DEST_DEN:  w_tgt = r_den;
            DEST_BNUM: w_tgt = r_bnum;
            DEST_ANUM: w_tgt = r_anum;
            default:   w_tgt = r_den;
        endcase
        w_sum = r_pop.sub ? (w_tgt - w_addend) : (w_tgt + w_addend);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fit_clr) begin
            r_den  <= '0;
            r_bnum <= '0;
            r_anum <= '0;
        end else if (r_mv) begin
            unique case (r_pop.dest)
                DEST_DEN:  r_den  <= w_sum;
                DEST_BNUM: r_bnum <= w_sum;
                DEST_ANUM: r_anum <= w_sum;
                default:   r_den  <= w_sum;
            endcase
        end
    end

    // magnitudes into the divider, sign of the quotient kept aside
    assign w_num_acc = i_cmd.div_num_a ? r_anum : r_bnum;
    assign w_num_mag = w_num_acc[ACC_W-1] ? (~w_num_acc + 1'b1) : w_num_acc;
    assign w_div_num = NUM_W'(w_num_mag) << FRAC_BITS;
    assign w_den_lo  = r_den[DEN_W-1:0];
    assign w_den_mag = r_den[ACC_W-1] ? (~w_den_lo + 1'b1) : w_den_lo;

    lsq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_div_num),
        .i_den   (w_den_mag),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_qneg <= w_num_acc[ACC_W-1] ^ r_den[ACC_W-1];
        end
        if (i_cmd.cap_b) begin
            r_b <= sat_q(w_quo, r_qneg);
        end
        if (i_cmd.cap_a) begin
            r_a <= sat_q(w_quo, r_qneg);
        end
        if (i_cmd.out_load) begin
            r_out_a <= i_cmd.out_zero ? '0 : r_a;
            r_out_b <= i_cmd.out_zero ? '0 : r_b;
        end
    end

    assign o_stat.ovf      = r_ovf;
    assign o_stat.den_zero = (r_den == '0);
    assign o_stat.div_done = w_div_done;
    assign o_intercept     = r_out_a;
    assign o_slope         = r_out_b;

endmodule

>>> rtl/lsq_ctrl.sv
// Controller: point intake, fit sequence and result handshake.
module lsq_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_last,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output lsq_pkg::t_fit_status  o_status,
    output lsq_pkg::t_dp_cmd      o_cmd,
    input  lsq_pkg::t_dp_stat     i_stat
);
    import lsq_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_fit_status       r_status;
    t_fit_status       n_status;
    t_fit_status       r_out_status;
    logic              r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ACCUM;
            r_step      <= '0;
            r_status    <= FIT_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_status <= n_status;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd.out_load) begin
            r_out_status <= r_status;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_status   = r_status;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_ACCUM: begin
                o_in_ready    = 1'b1;
                o_cmd.pt_load = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last point settles into the sums this cycle
                o_cmd.fit_clr = 1'b1;
                n_step        = '0;
                n_state       = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul_valid = 1'b1;
                o_cmd.mul_op    = lsq_mul_step(r_step);
                if (r_step == STEP_W'(N_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = ST_MWAIT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_MWAIT: begin
                if (r_step == STEP_W'(MUL_LAT - 1)) begin
                    n_step  = '0;
                    n_state = ST_CHECK;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_CHECK: begin
                priority if (i_stat.ovf) begin
                    n_status = FIT_TOO_MANY;
                    n_state  = ST_DONE;
                end else if (i_stat.den_zero) begin
                    n_status = FIT_DEN_ZERO;
                    n_state  = ST_DONE;
                end else begin
                    n_status        = FIT_OK;
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV_B;
                end
            end
            ST_DIV_B: begin
                if (i_stat.div_done) begin
                    o_cmd.cap_b     = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_num_a = 1'b1;
                    n_state         = ST_DIV_A;
                end
            end
            ST_DIV_A: begin
                if (i_stat.div_done) begin
                    o_cmd.cap_a = 1'b1;
                    n_state     = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_zero = (r_status != FIT_OK);
                    o_cmd.sum_clr  = 1'b1;
                    n_state        = ST_ACCUM;
                end
            end
            default: begin
                n_state = ST_ACCUM;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;

endmodule

>>> rtl/least_squares_line_fit.sv
// Top level of the least-squares line fitter.
//
// Usage:
//   i_pt carries points (x_value, y_value, last_point) under valid/ready.
//   o_fit carries one result per set: intercept_q16 and slope_q16 in signed
//   Q.16, truncated toward zero and saturated to 48 bits, and fit_status
//   (0 valid, 1 zero denominator, 2 more than 1024 points).
//   Points are taken one per cycle. The point with last_point set closes the
//   set; ready then stays low while the fit runs. The fit runs its multiply
//   steps on the shared 27x22 multiplier, then two 86-bit divisions on the
//   one divider; when the set is flagged, no division runs.
//   The result sits in an output register; the next set is accepted while it
//   waits. If the receiver still stalls when the following set closes, the
//   fit holds in its last state until the register is taken.
//   Reset (synchronous, active low) clears the sums, the point count, the
//   overflow flag and the output valid. Sums clear again after every result.
module least_squares_line_fit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lsq_pt_if.sink       i_pt,
    lsq_fit_if.source    o_fit
);
    import lsq_pkg::*;

    t_dp_cmd     w_cmd;
    t_dp_stat    w_stat;
    t_fit_status w_status;

    lsq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pt.valid),
        .i_in_last   (i_pt.last_point),
        .o_in_ready  (i_pt.ready),
        .o_out_valid (o_fit.valid),
        .i_out_ready (o_fit.ready),
        .o_status    (w_status),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    lsq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_x         (i_pt.x_value),
        .i_y         (i_pt.y_value),
        .o_stat      (w_stat),
        .o_intercept (o_fit.intercept_q16),
        .o_slope     (o_fit.slope_q16)
    );

    assign o_fit.fit_status = w_status;

endmodule

>>> verif/lsq_fit_checker.sv
// Line-fit checker: rebuilds each fit from the observed points and compares every result.
`timescale 1ns / 100ps

module lsq_fit_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    lsq_pt_if    i_pt,
    lsq_fit_if   i_fit,
    output int   o_errors,
    output int   o_pending,
    output int   o_points,
    output int   o_fits_ok,
    output int   o_fits_den_zero,
    output int   o_fits_too_many
);
    import lsq_pkg::*;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic signed [OUT_W-1:0] intercept;
        logic signed [OUT_W-1:0] slope;
        t_fit_status             status;
    } t_line_fit;

    localparam t_wide Q16_MAX = (t_wide'(1) <<< (OUT_W - 1)) - t_wide'(1);
    localparam t_wide Q16_MIN = -(t_wide'(1) <<< (OUT_W - 1));

    int unsigned set_points;
    longint      sum_x;
    longint      sum_y;
    longint      sum_xy;
    longint      sum_xx;
    bit          set_overflow;
    t_line_fit   fits_due[$];

    int mismatches;
    int points_seen;
    int fits_seen;
    int n_ok;
    int n_den_zero;
    int n_too_many;

    assign o_errors        = mismatches;
    assign o_points        = points_seen;
    assign o_fits_ok       = n_ok;
    assign o_fits_den_zero = n_den_zero;
    assign o_fits_too_many = n_too_many;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task automatic clear_set();
        set_points   = 0;
        sum_x        = 0;
        sum_y        = 0;
        sum_xy       = 0;
        sum_xx       = 0;
        set_overflow = 1'b0;
    endtask

    function automatic logic signed [OUT_W-1:0] clamp_q16(input t_wide q);
        if (q > Q16_MAX)
            return Q16_MAX[OUT_W-1:0];
        if (q < Q16_MIN)
            return Q16_MIN[OUT_W-1:0];
        return q[OUT_W-1:0];
    endfunction

    // Division of signed operands truncates toward zero, as the fit requires.
    function automatic t_line_fit solve_line();
        t_line_fit fit;
        longint    n;
        longint    den;
        t_wide     w_den;
        t_wide     w_bnum;
        t_wide     w_anum;
        n = longint'(set_points);
        den = n * sum_xx - sum_x * sum_x;
        fit.intercept = '0;
        fit.slope     = '0;
        if (set_overflow) begin
            fit.status = FIT_TOO_MANY;
        end else if (den == 0) begin
            fit.status = FIT_DEN_ZERO;
        end else begin
            fit.status = FIT_OK;
            w_den  = t_wide'(den);
            w_bnum = t_wide'(n * sum_xy - sum_x * sum_y) <<< FRAC_BITS;
            w_anum = t_wide'(sum_y) * t_wide'(sum_xx) - t_wide'(sum_x) * t_wide'(sum_xy);
            w_anum = w_anum <<< FRAC_BITS;
            fit.slope     = clamp_q16(w_bnum / w_den);
            fit.intercept = clamp_q16(w_anum / w_den);
        end
        return fit;
    endfunction

    task automatic take_point(input logic signed [X_W-1:0] x,
                              input logic signed [Y_W-1:0] y,
                              input logic closes);
        longint xl;
        longint yl;
        xl = x;
        yl = y;
        points_seen++;
        // Drop points past the limit, but remember that the set overflowed.
        if (set_points >= MAX_POINTS) begin
            set_overflow = 1'b1;
        end else begin
            set_points++;
            sum_x  += xl;
            sum_y  += yl;
            sum_xy += xl * yl;
            sum_xx += xl * xl;
        end
        if (closes) begin
            fits_due.push_back(solve_line());
            clear_set();
        end
    endtask

    task automatic check_fit();
        t_line_fit want;
        fits_seen++;
        if (fits_due.size() == 0) begin
            report_mismatch($sformatf("fit %0d arrived with no set closed", fits_seen));
            return;
        end
        want = fits_due.pop_front();
        case (want.status)
            FIT_OK:       n_ok++;
            FIT_DEN_ZERO: n_den_zero++;
            FIT_TOO_MANY: n_too_many++;
            default:      n_too_many++;
        endcase
        if (i_fit.fit_status !== want.status)
            report_mismatch($sformatf("fit %0d status got %0d, want %0d",
                                      fits_seen, i_fit.fit_status, want.status));
        if (i_fit.intercept_q16 !== want.intercept)
            report_mismatch($sformatf("fit %0d intercept got %0d, want %0d",
                                      fits_seen, i_fit.intercept_q16, want.intercept));
        if (i_fit.slope_q16 !== want.slope)
            report_mismatch($sformatf("fit %0d slope got %0d, want %0d",
                                      fits_seen, i_fit.slope_q16, want.slope));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_set();
            fits_due.delete();
        end else begin
            if (i_pt.valid && i_pt.ready)
                take_point(i_pt.x_value, i_pt.y_value, i_pt.last_point);
            if (i_fit.valid && i_fit.ready)
                check_fit();
        end
        o_pending <= fits_due.size();
    end

endmodule

>>> verif/tb_least_squares_line_fit.sv
// Testbench top of the line fitter: clock, reset, point stimulus, result stalls and verdict.
`timescale 1ns / 100ps

module tb_least_squares_line_fit;
    import lsq_pkg::*;

    localparam int RANDOM_POINTS = 580;
    localparam int IDLE_LIMIT    = 4000;
    localparam int FIT_LATENCY   = 250;
    localparam int HOLD_CYCLES   = 700;
    localparam int HOLD_EVERY    = 38;

    typedef enum {MIX_FULL, MIX_EDGE, MIX_SMALL, MIX_CLUSTER} t_coord_mix;
    typedef enum {SET_LINE, SET_FLAT_X, SET_SINGLE, SET_NOISE} t_set_kind;

    logic i_clk;
    logic i_rst_n;

    lsq_pt_if  pt_ch ();
    lsq_fit_if fit_ch ();

    int errors;
    int pending;
    int points_seen;
    int fits_ok;
    int fits_den_zero;
    int fits_too_many;

    int points_sent;
    int burst_left;
    int long_holds;

    least_squares_line_fit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_ch),
        .o_fit   (fit_ch)
    );

    lsq_fit_checker fit_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_pt            (pt_ch),
        .i_fit           (fit_ch),
        .o_errors        (errors),
        .o_pending       (pending),
        .o_points        (points_seen),
        .o_fits_ok       (fits_ok),
        .o_fits_den_zero (fits_den_zero),
        .o_fits_too_many (fits_too_many)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic signed [X_W-1:0] pick_coord(input t_coord_mix mix);
        logic signed [X_W-1:0] v;
        case (mix)
            MIX_FULL: begin
                v = X_W'($urandom);
            end
            MIX_EDGE: begin
                case ($urandom_range(0, 5))
                    0:       v = 16'sh8000;
                    1:       v = 16'sh7FFF;
                    2:       v = 16'sh0000;
                    3:       v = -16'sd1;
                    4:       v = 16'sd1;
                    default: v = 16'sh8001;
                endcase
            end
            MIX_SMALL: begin
                v = X_W'(int'($urandom_range(0, 16)) - 8);
            end
            default: begin
                if ($urandom_range(0, 1))
                    v = X_W'(32767 - int'($urandom_range(0, 7)));
                else
                    v = X_W'(-32768 + int'($urandom_range(0, 7)));
            end
        endcase
        return v;
    endfunction

    // Offer one point, hold it until taken, then maybe end the burst with a gap.
    task automatic send_point(input logic signed [X_W-1:0] x,
                              input logic signed [Y_W-1:0] y,
                              input logic closes);
        int gap;
        pt_ch.valid      <= 1'b1;
        pt_ch.x_value    <= x;
        pt_ch.y_value    <= y;
        pt_ch.last_point <= closes;
        @(posedge i_clk);
        while (!pt_ch.ready)
            @(posedge i_clk);
        points_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 7) == 0)
                gap = $urandom_range(20, 300);
            else if ($urandom_range(0, 1))
                gap = 0;
            else
                gap = $urandom_range(1, 6);
            if (gap > 0) begin
                pt_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_set(input t_set_kind kind, input int n_pts,
                            input t_coord_mix xmix, input t_coord_mix ymix);
        logic signed [X_W-1:0] flat_x;
        logic signed [X_W-1:0] x;
        flat_x = pick_coord(xmix);
        for (int i = 0; i < n_pts; i++) begin
            if (kind == SET_NOISE) begin
                xmix = t_coord_mix'($urandom_range(0, 3));
                ymix = t_coord_mix'($urandom_range(0, 3));
            end
            x = (kind == SET_FLAT_X) ? flat_x : pick_coord(xmix);
            send_point(x, pick_coord(ymix), i == n_pts - 1);
        end
    endtask

    task automatic send_random_set();
        int        pick;
        int        n_pts;
        t_set_kind kind;
        pick = $urandom_range(0, 9);
        if (pick <= 6) begin
            kind  = SET_LINE;
            n_pts = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60)
                                                : $urandom_range(2, 12);
        end else if (pick == 7) begin
            kind  = SET_FLAT_X;
            n_pts = $urandom_range(2, 8);
        end else if (pick == 8) begin
            kind  = SET_SINGLE;
            n_pts = 1;
        end else begin
            kind  = SET_NOISE;
            n_pts = $urandom_range(1, 40);
        end
        send_set(kind, n_pts, t_coord_mix'($urandom_range(0, 3)),
                 t_coord_mix'($urandom_range(0, 3)));
    endtask

    // Result side: a changing stall pattern, plus long hold-offs that back up the input.
    initial begin : fit_receiver
        int unsigned fits_taken;
        int unsigned hold_left;
        int unsigned next_hold_at;
        int unsigned pat_age;
        logic [7:0]  stall_pat;
        fits_taken   = 0;
        hold_left    = 0;
        next_hold_at = 12;
        pat_age      = 0;
        stall_pat    = 8'hFF;
        long_holds   = 0;
        fit_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (fit_ch.valid && fit_ch.ready)
                fits_taken++;
            if (fits_taken >= next_hold_at) begin
                hold_left     = HOLD_CYCLES;
                next_hold_at += HOLD_EVERY;
                long_holds++;
            end
            if (pat_age % 96 == 0) begin
                case ($urandom_range(0, 3))
                    0:       stall_pat = 8'hFF;
                    1:       stall_pat = 8'($urandom);
                    2:       stall_pat = 8'h11;
                    default: stall_pat = 8'h80;
                endcase
            end
            pat_age++;
            if (hold_left > 0) begin
                hold_left--;
                fit_ch.ready <= 1'b0;
            end else begin
                fit_ch.ready <= stall_pat[pat_age % 8];
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((pt_ch.valid && pt_ch.ready) || (fit_ch.valid && fit_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("watchdog: no request moved for %0d cycles, %0d fits still due",
                 IDLE_LIMIT, pending);
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        int rand_base;
        pt_ch.valid      <= 1'b0;
        pt_ch.x_value    <= '0;
        pt_ch.y_value    <= '0;
        pt_ch.last_point <= 1'b0;
        i_rst_n          <= 1'b0;
        points_sent = 0;
        burst_left  = $urandom_range(1, 40);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single point: zero denominator
        send_point(-16'sd32768, 16'sd32767, 1'b1);
        // all x equal: zero denominator
        send_point(16'sd5, 16'sd1, 1'b0);
        send_point(16'sd5, -16'sd3, 1'b0);
        send_point(16'sd5, 16'sd7, 1'b1);
        send_point(-16'sd32768, 16'sd0, 1'b0);
        send_point(-16'sd32768, 16'sd5, 1'b1);
        // corner to corner
        send_point(-16'sd32768, -16'sd32768, 1'b0);
        send_point(16'sd32767, 16'sd32767, 1'b1);
        // steepest slopes far from the origin: largest intercepts
        send_point(16'sd32766, -16'sd32768, 1'b0);
        send_point(16'sd32767, 16'sd32767, 1'b1);
        send_point(-16'sd32768, 16'sd32767, 1'b0);
        send_point(-16'sd32767, -16'sd32768, 1'b1);
        // flat line through the origin
        send_point(16'sd1, 16'sd0, 1'b0);
        send_point(-16'sd1, 16'sd0, 1'b1);
        send_point(-16'sd32768, 16'sd32767, 1'b0);
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(16'sd32767, -16'sd32768, 1'b1);
        // fractional results, truncated toward zero
        send_point(16'sd0, -16'sd1, 1'b0);
        send_point(16'sd1, 16'sd2, 1'b0);
        send_point(16'sd3, -16'sd2, 1'b1);

        rand_base = points_sent;
        while (points_sent - rand_base < RANDOM_POINTS / 2)
            send_random_set();
        // a set that runs past the point limit
        send_set(SET_NOISE, MAX_POINTS + 3, MIX_FULL, MIX_FULL);
        rand_base = points_sent;
        while (points_sent - rand_base < RANDOM_POINTS / 2)
            send_random_set();
        pt_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (FIT_LATENCY) @(posedge i_clk);

        $display("run covered %0d points and %0d fits: %0d valid, %0d flat in x, %0d overfull",
                 points_seen, fits_ok + fits_den_zero + fits_too_many,
                 fits_ok, fits_den_zero, fits_too_many);
        $display("result side held off %0d times for %0d cycles each", long_holds, HOLD_CYCLES);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
